>>> design/eul_pkg.sv
package eul_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int COST_WIDTH  = VALUE_WIDTH - 1;
    localparam int SQ_WIDTH    = 2 * VALUE_WIDTH;
    localparam int ROOT_WIDTH  = VALUE_WIDTH;
    localparam int REM_WIDTH   = VALUE_WIDTH + 2;
    localparam int SUM_WIDTH   = VALUE_WIDTH + 1;
    localparam int DIV_SHIFT   = SUM_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * SUM_WIDTH;
    localparam int N_CELLS     = ROOT_WIDTH;

    // reciprocal of three, exact for every sum below 2**SUM_WIDTH
    localparam logic [63:0] DIV3_FULL = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
    localparam logic [SUM_WIDTH-1:0] DIV3_MUL = DIV3_FULL[SUM_WIDTH-1:0];

    typedef logic [VALUE_WIDTH-1:0] t_val;

    localparam t_val INF = '1;

    typedef struct packed {
        t_val                  lo;
        t_val                  d2;
        t_val                  d3;
        logic [COST_WIDTH-1:0] h;
        t_val                  present;
        logic                  no_upd;
        logic                  ok3;
        logic                  ok2;
    } t_side;

    typedef struct packed {
        logic [SQ_WIDTH-1:0]   rad;
        logic [REM_WIDTH-1:0]  rem;
        logic [ROOT_WIDTH-1:0] root;
    } t_sq;

    typedef struct packed {
        logic  vld;
        t_sq   s3;
        t_sq   s2;
        t_side side;
    } t_cell;

endpackage

>>> design/eul_sqrt_cell.sv
module eul_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  eul_pkg::t_cell i_d,
    output eul_pkg::t_cell o_d
);
    import eul_pkg::*;

    // one root bit of restoring square root
    function automatic t_sq sq_step(t_sq s);
        logic [REM_WIDTH+1:0] rem_sh;
        logic [REM_WIDTH+1:0] trial;
        t_sq r;
        rem_sh = {s.rem, s.rad[SQ_WIDTH-1 -: 2]};
        trial  = {{(REM_WIDTH - ROOT_WIDTH){1'b0}}, s.root, 2'b01};
        r.rad  = {s.rad[SQ_WIDTH-3:0], 2'b00};
        if (rem_sh >= trial) begin
            r.rem  = REM_WIDTH'(rem_sh - trial);
            r.root = {s.root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
            r.rem  = REM_WIDTH'(rem_sh);
            r.root = {s.root[ROOT_WIDTH-2:0], 1'b0};
        end
        return r;
    endfunction

    t_cell r_q;
    t_cell n_q;

    always_comb begin
        n_q      = i_d;
        n_q.s3   = sq_step(i_d.s3);
        n_q.s2   = sq_step(i_d.s2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_d = r_q;

endmodule

>>> design/eul_prep.sv
module eul_prep (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_vld,
    input  eul_pkg::t_val                  i_xm,
    input  eul_pkg::t_val                  i_xp,
    input  eul_pkg::t_val                  i_ym,
    input  eul_pkg::t_val                  i_yp,
    input  eul_pkg::t_val                  i_zm,
    input  eul_pkg::t_val                  i_zp,
    input  logic [eul_pkg::COST_WIDTH-1:0] i_h,
    input  eul_pkg::t_val                  i_present,
    input  logic                           i_bnd,
    output eul_pkg::t_cell                 o_d
);
    import eul_pkg::*;

    logic [6:0] r_vld;

    // stage 1: axis minima
    t_val r1_a1, r1_a2, r1_a3, r1_present;
    logic [COST_WIDTH-1:0] r1_h;
    logic r1_bnd;
    // stage 2: sorted
    t_val r2_lo, r2_mid, r2_hi, r2_present;
    logic [COST_WIDTH-1:0] r2_h;
    logic r2_bnd;
    // stage 3: offsets
    t_side r3_side;
    logic  r3_c3, r3_c2;
    t_val  r3_e;
    // stage 4: squares
    t_side r4_side;
    logic  r4_c3, r4_c2;
    logic [SQ_WIDTH-1:0] r4_h2, r4_d2s, r4_d3s, r4_es;
    // stage 5: partial sums
    t_side r5_side;
    logic  r5_c3, r5_c2;
    logic [SQ_WIDTH-1:0] r5_tt3, r5_tt2, r5_s1, r5_es, r5_d2s;
    // stage 6: full p
    t_side r6_side;
    logic  r6_c3, r6_c2;
    logic [SQ_WIDTH-1:0] r6_tt3, r6_tt2, r6_p, r6_d2s;
    // stage 7: discriminants
    t_cell r7_d;

    t_val n2_lo, n2_mid, n2_hi, t0, t1, t2;
    t_side n7_side;

    always_comb begin
        t0 = r1_a1;
        t1 = r1_a2;
        t2 = r1_a3;
        if (t0 > t1) begin
            {t0, t1} = {t1, t0};
        end
        if (t1 > t2) begin
            {t1, t2} = {t2, t1};
        end
        if (t0 > t1) begin
            {t0, t1} = {t1, t0};
        end
        n2_lo  = t0;
        n2_mid = t1;
        n2_hi  = t2;
    end

    always_comb begin
        n7_side     = r6_side;
        n7_side.ok3 = r6_c3 && (r6_p <= r6_tt3);
        n7_side.ok2 = r6_c2 && (r6_d2s <= r6_tt2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_a1      <= (i_xm < i_xp) ? i_xm : i_xp;
            r1_a2      <= (i_ym < i_yp) ? i_ym : i_yp;
            r1_a3      <= (i_zm < i_zp) ? i_zm : i_zp;
            r1_h       <= i_h;
            r1_present <= i_present;
            r1_bnd     <= i_bnd;

            r2_lo      <= n2_lo;
            r2_mid     <= n2_mid;
            r2_hi      <= n2_hi;
            r2_h       <= r1_h;
            r2_present <= r1_present;
            r2_bnd     <= r1_bnd;

            r3_side.lo      <= r2_lo;
            r3_side.d2      <= r2_mid - r2_lo;
            r3_side.d3      <= r2_hi - r2_lo;
            r3_side.h       <= r2_h;
            r3_side.present <= r2_present;
            // lo infinite means every minimum is infinite
            r3_side.no_upd  <= r2_bnd || (r2_lo == INF);
            r3_side.ok3     <= 1'b0;
            r3_side.ok2     <= 1'b0;
            r3_c3 <= (r2_hi != INF) && ((r2_hi - r2_lo) < {1'b0, r2_h});
            r3_c2 <= (r2_mid != INF) && ((r2_mid - r2_lo) < {1'b0, r2_h});
            r3_e  <= r2_hi - r2_mid;

            r4_side <= r3_side;
            r4_c3   <= r3_c3;
            r4_c2   <= r3_c2;
            r4_h2   <= SQ_WIDTH'({1'b0, r3_side.h} * {1'b0, r3_side.h});
            r4_d2s  <= r3_side.d2 * r3_side.d2;
            r4_d3s  <= r3_side.d3 * r3_side.d3;
            r4_es   <= r3_e * r3_e;

            r5_side <= r4_side;
            r5_c3   <= r4_c3;
            r5_c2   <= r4_c2;
            r5_tt3  <= r4_h2 + {r4_h2[SQ_WIDTH-2:0], 1'b0};
            r5_tt2  <= {r4_h2[SQ_WIDTH-2:0], 1'b0};
            r5_s1   <= r4_d2s + r4_d3s;
            r5_es   <= r4_es;
            r5_d2s  <= r4_d2s;

            r6_side <= r5_side;
            r6_c3   <= r5_c3;
            r6_c2   <= r5_c2;
            r6_tt3  <= r5_tt3;
            r6_tt2  <= r5_tt2;
            r6_p    <= r5_s1 + r5_es;
            r6_d2s  <= r5_d2s;

            r7_d.vld      <= r_vld[5];
            r7_d.side     <= n7_side;
            r7_d.s3.rad   <= r6_tt3 - r6_p;
            r7_d.s3.rem   <= '0;
            r7_d.s3.root  <= '0;
            r7_d.s2.rad   <= r6_tt2 - r6_d2s;
            r7_d.s2.rem   <= '0;
            r7_d.s2.root  <= '0;
        end
    end

    always_comb begin
        o_d     = r7_d;
        o_d.vld = r_vld[6];
    end

endmodule

>>> design/eikonal_3d_local_update.sv
// channel | direction | handshake                 | payload
// in      | into      | i_in_valid / o_in_stall   | six neighbor times, cost, present, boundary
// out     | out of    | o_out_valid / i_out_stall | updated time, improved flag
//
// one item per cycle while no result waits under stall
// the pipe is made of 7 setup stages, a row of 32 square root cells
// (one root bit per cell, both solves side by side) and 5 finishing stages
// synchronous active-low reset clears the valid bits only
// the whole pipe holds while a result waits under stall
module eikonal_3d_local_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [31:0]                    i_x_minus_time,
    input  logic [31:0]                    i_x_plus_time,
    input  logic [31:0]                    i_y_minus_time,
    input  logic [31:0]                    i_y_plus_time,
    input  logic [31:0]                    i_z_minus_time,
    input  logic [31:0]                    i_z_plus_time,
    input  logic [30:0]                    i_cell_cost,
    input  logic [31:0]                    i_present_time,
    input  logic                           i_is_boundary,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [31:0]                    o_updated_time,
    output logic                           o_improved
);
    import eul_pkg::*;

    logic  adv;
    t_cell chain [0:N_CELLS];

    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    eul_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_vld     (i_in_valid),
        .i_xm      (i_x_minus_time),
        .i_xp      (i_x_plus_time),
        .i_ym      (i_y_minus_time),
        .i_yp      (i_y_plus_time),
        .i_zm      (i_z_minus_time),
        .i_zp      (i_z_plus_time),
        .i_h       (i_cell_cost),
        .i_present (i_present_time),
        .i_bnd     (i_is_boundary),
        .o_d       (chain[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        eul_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_d     (chain[g]),
            .o_d     (chain[g+1])
        );
    end

    t_cell last;
    assign last = chain[N_CELLS];

    logic [3:0] r_vld;
    logic       r_out_valid;

    t_side r1_side;
    logic [SUM_WIDTH-1:0] r1_s3;
    t_val  r1_w2;
    t_side r2_side;
    logic [PROD_WIDTH-1:0] r2_prod;
    t_val  r2_w2;
    t_side r3_side;
    t_val  r3_w;
    t_side r4_side;
    t_val  r4_nv;
    t_val  r_out_time;
    logic  r_out_imp;

    t_val n3_w3;
    t_val n3_w;
    logic [SUM_WIDTH-1:0] n1_s2;
    logic [SUM_WIDTH-1:0] n4_sum;

    assign n1_s2 = {1'b0, last.side.d2} + {1'b0, last.s2.root};
    assign n3_w3 = r2_prod[DIV_SHIFT +: VALUE_WIDTH];

    always_comb begin
        if (r2_side.ok3 && (n3_w3 > r2_side.d3)) begin
            n3_w = n3_w3;
        end else if (r2_side.ok2 && (r2_w2 > r2_side.d2)) begin
            n3_w = r2_w2;
        end else begin
            n3_w = {1'b0, r2_side.h};
        end
    end

    assign n4_sum = {1'b0, r3_side.lo} + {1'b0, r3_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[2:0], last.vld};
            r_out_valid <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side <= last.side;
            r1_s3   <= {1'b0, last.side.d2} + {1'b0, last.side.d3} + {1'b0, last.s3.root};
            r1_w2   <= n1_s2[SUM_WIDTH-1:1];

            // floor of the sum over three by reciprocal
            r2_side <= r1_side;
            r2_prod <= r1_s3 * DIV3_MUL;
            r2_w2   <= r1_w2;

            r3_side <= r2_side;
            r3_w    <= n3_w;

            r4_side <= r3_side;
            r4_nv   <= (n4_sum >= {1'b0, INF}) ? INF : n4_sum[VALUE_WIDTH-1:0];

            if (!r4_side.no_upd && (r4_nv < r4_side.present)) begin
                r_out_time <= r4_nv;
                r_out_imp  <= 1'b1;
            end else begin
                r_out_time <= r4_side.present;
                r_out_imp  <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_updated_time = r_out_time;
    assign o_improved     = r_out_imp;

endmodule

>>> design/eul_checker.sv
module eul_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_updated_time,
    input logic        o_improved
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_updated_time)
                                       && $stable(o_improved))
        else $error("stalled result changed");

    a_imp_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_improved |-> o_updated_time != 32'hffff_ffff)
        else $error("improved result is infinite");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind eikonal_3d_local_update eul_checker u_eul_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_updated_time (o_updated_time),
    .o_improved     (o_improved)
);
